### hdl/cpr_pkg.sv
package cpr_pkg;

	localparam int DEF_MAX_DEGREE = 16;
	localparam int DEF_PART_WIDTH = 32;
	localparam int DEF_FRAC_BITS  = 16;

	localparam logic [1:0] OP_WRITE_ROOT = 2'd0;
	localparam logic [1:0] OP_READ_COEF  = 2'd1;
	localparam logic [1:0] OP_EVALUATE   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_SAT   = 2'd2;

	localparam logic [1:0] REG_DEGREE  = 2'd0;
	localparam logic [1:0] REG_LEAD_RE = 2'd1;
	localparam logic [1:0] REG_LEAD_IM = 2'd2;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_READ   = 2'd1,
		CMD_EVAL   = 2'd2,
		CMD_REJECT = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [4:0]  slot;
		logic [31:0] re;
		logic [31:0] im;
	} cmd_t;

	typedef struct packed {
		logic [31:0] re;
		logic [31:0] im;
		logic [1:0]  status;
	} out_item_t;

	typedef struct packed {
		logic rebuild;
		logic clear_roots;
	} cfg_evt_t;

	// fixed-point one, clamped to the largest part value
	function automatic int one_part(input int frac, input int width);
		int r;
		if (frac >= width - 1) begin
			r = (2 ** (width - 1)) - 1;
		end else begin
			r = 1 << frac;
		end
		return r;
	endfunction

endpackage

### hdl/cpr_fifo.sv
module cpr_fifo #(
	parameter type item_t = logic [0:0]
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  item_t wr_data,
	output logic  full,
	input  logic  rd_en,
	output item_t rd_data,
	output logic  empty
);

	item_t      mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en && !full) begin
				wp_q <= ~wp_q;
			end
			if (rd_en && !empty) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'((wr_en && !full) ? 1 : 0) - 2'((rd_en && !empty) ? 1 : 0);
		end
	end

endmodule

### hdl/cpr_front.sv
module cpr_front import cpr_pkg::*; #(
	parameter int MAX_DEGREE = DEF_MAX_DEGREE,
	localparam int DW = $clog2(MAX_DEGREE + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [1:0]    operation,
	input  logic [4:0]    slot,
	input  logic [31:0]   value_re,
	input  logic [31:0]   value_im,
	input  logic [DW-1:0] degree,
	input  logic          cmd_pop,
	output cmd_t          cmd,
	output logic          cmd_empty
);

	cmd_t in_cmd;

	// classify against the degree in force; the user must move degree only while idle, the block does not enforce it
	always_comb begin
		in_cmd.slot = slot;
		in_cmd.re   = value_re;
		in_cmd.im   = value_im;
		unique case (operation)
			OP_WRITE_ROOT: in_cmd.kind = (32'(slot) < 32'(degree)) ? CMD_WRITE : CMD_REJECT;
			OP_READ_COEF:  in_cmd.kind = (32'(slot) <= 32'(degree)) ? CMD_READ : CMD_REJECT;
			OP_EVALUATE:   in_cmd.kind = CMD_EVAL;
			default:       in_cmd.kind = CMD_REJECT;
		endcase
	end

	cpr_fifo #(.item_t(cmd_t)) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (in_cmd),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (cmd),
		.empty   (cmd_empty)
	);

endmodule

### hdl/cpr_engine.sv
module cpr_engine import cpr_pkg::*; #(
	parameter int MAX_DEGREE = DEF_MAX_DEGREE,
	parameter int PART_WIDTH = DEF_PART_WIDTH,
	parameter int FRAC_BITS  = DEF_FRAC_BITS,
	localparam int DW = $clog2(MAX_DEGREE + 1),
	localparam int PW = PART_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [DW-1:0]        degree,
	input  logic signed [PW-1:0] lead_re,
	input  logic signed [PW-1:0] lead_im,
	input  cfg_evt_t             evt,
	input  cmd_t                 cmd,
	input  logic                 cmd_empty,
	output logic                 cmd_pop,
	output out_item_t            res,
	output logic                 res_push,
	input  logic                 res_full
);

	localparam int NC = MAX_DEGREE + 1;
	localparam int RW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int XW = 2 * PW + 1;
	localparam logic signed [XW-1:0] WMAX = XW'((2 ** (PW - 1)) - 1);
	localparam logic signed [XW-1:0] WMIN = -WMAX - XW'(1);
	localparam logic signed [PW-1:0] ONE  = PW'(one_part(FRAC_BITS, PW));

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_RBSTART = 6'b000010,
		S_COPY    = 6'b000100,
		S_LOAD    = 6'b001000,
		S_MUL     = 6'b010000,
		S_FIN     = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		K_ROOT = 2'd0,
		K_LEAD = 2'd1,
		K_HORN = 2'd2
	} kind_t;

	state_t state_q;
	kind_t  kind_q;

	logic signed [PW-1:0] root_re_q [MAX_DEGREE];
	logic signed [PW-1:0] root_im_q [MAX_DEGREE];
	logic signed [PW-1:0] coef_re_q [NC];
	logic signed [PW-1:0] coef_im_q [NC];
	logic signed [PW-1:0] scr_re_q  [NC];
	logic signed [PW-1:0] scr_im_q  [NC];

	logic [DW-1:0] i_q;
	logic [DW-1:0] j_q;
	logic [1:0]    ph_q;
	logic          pend_q;
	logic          report_q;
	logic          sat_q;

	logic signed [PW-1:0]   a_re_q, a_im_q, b_re_q, b_im_q, c_re_q, c_im_q;
	logic signed [PW-1:0]   cur_re_q, cur_im_q, acc_re_q, acc_im_q, pt_re_q, pt_im_q;
	logic                   sub_q;
	logic signed [2*PW-1:0] p_q [4];
	out_item_t              res_q;
	logic                   res_push_q;

	function automatic logic [PW:0] sat_part(input logic signed [XW-1:0] v);
		logic [PW:0] r;
		if (v > WMAX) begin
			r = {1'b1, WMAX[PW-1:0]};
		end else if (v < WMIN) begin
			r = {1'b1, WMIN[PW-1:0]};
		end else begin
			r = {1'b0, v[PW-1:0]};
		end
		return r;
	endfunction

	// single scratch read port
	logic [DW-1:0]        scr_ra;
	logic signed [PW-1:0] scr_rd_re, scr_rd_im;

	always_comb begin
		if (state_q == S_COPY) begin
			scr_ra = i_q;
		end else if (kind_q == K_ROOT) begin
			scr_ra = (j_q == '0) ? '0 : j_q - DW'(1);
		end else begin
			scr_ra = j_q;
		end
	end

	assign scr_rd_re = scr_re_q[scr_ra];
	assign scr_rd_im = scr_im_q[scr_ra];

	// one real product per cycle
	logic signed [PW-1:0]   mx, my;
	logic signed [2*PW-1:0] prod;

	always_comb begin
		case (ph_q)
			2'd0:    begin mx = a_re_q; my = b_re_q; end
			2'd1:    begin mx = a_im_q; my = b_im_q; end
			2'd2:    begin mx = a_re_q; my = b_im_q; end
			default: begin mx = a_im_q; my = b_re_q; end
		endcase
	end

	assign prod = mx * my;

	// scale, saturate, then add or subtract the carried term
	logic signed [XW-1:0] sum_re, sum_im, add_re, add_im;
	logic [PW:0]          pre_re, pre_im, fr, fi;
	logic signed [PW-1:0] m_re, m_im, fin_re, fin_im;
	logic                 fin_sat;

	always_comb begin
		sum_re  = XW'(p_q[0]) - XW'(p_q[1]);
		sum_im  = XW'(p_q[2]) + XW'(p_q[3]);
		pre_re  = sat_part(sum_re >>> FRAC_BITS);
		pre_im  = sat_part(sum_im >>> FRAC_BITS);
		m_re    = signed'(pre_re[PW-1:0]);
		m_im    = signed'(pre_im[PW-1:0]);
		add_re  = sub_q ? XW'(c_re_q) - XW'(m_re) : XW'(c_re_q) + XW'(m_re);
		add_im  = sub_q ? XW'(c_im_q) - XW'(m_im) : XW'(c_im_q) + XW'(m_im);
		fr      = sat_part(add_re);
		fi      = sat_part(add_im);
		fin_re  = signed'(fr[PW-1:0]);
		fin_im  = signed'(fi[PW-1:0]);
		fin_sat = pre_re[PW] | pre_im[PW] | fr[PW] | fi[PW];
	end

	assign cmd_pop  = (state_q == S_IDLE) && !pend_q && !cmd_empty && !res_full && !res_push_q;
	assign res      = res_q;
	assign res_push = res_push_q;

	// scratch polynomial: no reset, every entry is written before it is read
	logic                 scr_we;
	logic [DW-1:0]        scr_wa;
	logic signed [PW-1:0] scr_wd_re, scr_wd_im;

	always_comb begin
		scr_we    = 1'b0;
		scr_wa    = j_q;
		scr_wd_re = fin_re;
		scr_wd_im = fin_im;
		if (state_q == S_RBSTART) begin
			scr_we    = (degree != '0);
			scr_wa    = '0;
			scr_wd_re = ONE;
			scr_wd_im = '0;
		end else if (state_q == S_COPY) begin
			scr_we    = 1'b1;
			scr_wa    = DW'(i_q + DW'(1));
			scr_wd_re = scr_rd_re;
			scr_wd_im = scr_rd_im;
		end else if (state_q == S_FIN && kind_q == K_ROOT) begin
			scr_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (scr_we) begin
			scr_re_q[scr_wa] <= scr_wd_re;
			scr_im_q[scr_wa] <= scr_wd_im;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			kind_q     <= K_ROOT;
			i_q        <= '0;
			j_q        <= '0;
			ph_q       <= '0;
			pend_q     <= 1'b0;
			report_q   <= 1'b0;
			sat_q      <= 1'b0;
			res_push_q <= 1'b0;
			res_q      <= '0;
			sub_q      <= 1'b0;
			a_re_q     <= '0;
			a_im_q     <= '0;
			b_re_q     <= '0;
			b_im_q     <= '0;
			c_re_q     <= '0;
			c_im_q     <= '0;
			cur_re_q   <= '0;
			cur_im_q   <= '0;
			acc_re_q   <= '0;
			acc_im_q   <= '0;
			pt_re_q    <= '0;
			pt_im_q    <= '0;
			for (int k = 0; k < 4; k++) begin
				p_q[k] <= '0;
			end
			for (int k = 0; k < MAX_DEGREE; k++) begin
				root_re_q[k] <= '0;
				root_im_q[k] <= '0;
			end
			for (int k = 0; k < NC; k++) begin
				coef_re_q[k] <= (k == 0) ? ONE : '0;
				coef_im_q[k] <= '0;
			end
		end else begin
			res_push_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pend_q) begin
						pend_q   <= 1'b0;
						report_q <= 1'b0;
						sat_q    <= 1'b0;
						state_q  <= S_RBSTART;
					end else if (cmd_pop) begin
						sat_q <= 1'b0;
						case (cmd.kind)
							CMD_WRITE: begin
								root_re_q[RW'(cmd.slot)] <= signed'(cmd.re[PW-1:0]);
								root_im_q[RW'(cmd.slot)] <= signed'(cmd.im[PW-1:0]);
								report_q <= 1'b1;
								state_q  <= S_RBSTART;
							end
							CMD_READ: begin
								res_q.re     <= 32'(coef_re_q[DW'(cmd.slot)]);
								res_q.im     <= 32'(coef_im_q[DW'(cmd.slot)]);
								res_q.status <= ST_OK;
								res_push_q   <= 1'b1;
							end
							CMD_EVAL: begin
								acc_re_q <= '0;
								acc_im_q <= '0;
								pt_re_q  <= signed'(cmd.re[PW-1:0]);
								pt_im_q  <= signed'(cmd.im[PW-1:0]);
								kind_q   <= K_HORN;
								j_q      <= degree;
								state_q  <= S_LOAD;
							end
							default: begin
								res_q.re     <= '0;
								res_q.im     <= '0;
								res_q.status <= ST_RANGE;
								res_push_q   <= 1'b1;
							end
						endcase
					end
				end
				S_RBSTART: begin
					if (degree == '0) begin
						coef_re_q[0] <= lead_re;
						coef_im_q[0] <= lead_im;
						res_q.re     <= '0;
						res_q.im     <= '0;
						res_q.status <= sat_q ? ST_SAT : ST_OK;
						res_push_q   <= report_q;
						state_q      <= S_IDLE;
					end else begin
						i_q     <= '0;
						state_q <= S_COPY;
					end
				end
				S_COPY: begin
					// hold the old top entry; the inner pass walks down from it
					cur_re_q <= scr_rd_re;
					cur_im_q <= scr_rd_im;
					j_q      <= i_q;
					kind_q   <= K_ROOT;
					state_q  <= S_LOAD;
				end
				S_LOAD: begin
					ph_q <= '0;
					case (kind_q)
						K_ROOT: begin
							a_re_q <= cur_re_q;
							a_im_q <= cur_im_q;
							b_re_q <= root_re_q[RW'(i_q)];
							b_im_q <= root_im_q[RW'(i_q)];
							c_re_q <= (j_q == '0) ? '0 : scr_rd_re;
							c_im_q <= (j_q == '0) ? '0 : scr_rd_im;
							sub_q  <= 1'b1;
						end
						K_LEAD: begin
							a_re_q <= scr_rd_re;
							a_im_q <= scr_rd_im;
							b_re_q <= lead_re;
							b_im_q <= lead_im;
							c_re_q <= '0;
							c_im_q <= '0;
							sub_q  <= 1'b0;
						end
						default: begin
							a_re_q <= acc_re_q;
							a_im_q <= acc_im_q;
							b_re_q <= pt_re_q;
							b_im_q <= pt_im_q;
							c_re_q <= coef_re_q[j_q];
							c_im_q <= coef_im_q[j_q];
							sub_q  <= 1'b0;
						end
					endcase
					state_q <= S_MUL;
				end
				S_MUL: begin
					p_q[ph_q] <= prod;
					ph_q      <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					sat_q <= sat_q | fin_sat;
					case (kind_q)
						K_ROOT: begin
							cur_re_q <= c_re_q;
							cur_im_q <= c_im_q;
							if (j_q != '0) begin
								j_q     <= j_q - DW'(1);
								state_q <= S_LOAD;
							end else if (DW'(i_q + DW'(1)) == degree) begin
								kind_q  <= K_LEAD;
								state_q <= S_LOAD;
							end else begin
								i_q     <= i_q + DW'(1);
								state_q <= S_COPY;
							end
						end
						K_LEAD: begin
							coef_re_q[j_q] <= fin_re;
							coef_im_q[j_q] <= fin_im;
							if (j_q == degree) begin
								res_q.re     <= '0;
								res_q.im     <= '0;
								res_q.status <= (sat_q | fin_sat) ? ST_SAT : ST_OK;
								res_push_q   <= report_q;
								state_q      <= S_IDLE;
							end else begin
								j_q     <= j_q + DW'(1);
								state_q <= S_LOAD;
							end
						end
						default: begin
							acc_re_q <= fin_re;
							acc_im_q <= fin_im;
							if (j_q == '0) begin
								res_q.re     <= 32'(fin_re);
								res_q.im     <= 32'(fin_im);
								res_q.status <= (sat_q | fin_sat) ? ST_SAT : ST_OK;
								res_push_q   <= 1'b1;
								state_q      <= S_IDLE;
							end else begin
								j_q     <= j_q - DW'(1);
								state_q <= S_LOAD;
							end
						end
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
			// degree write: drop roots at and beyond the new degree
			if (evt.clear_roots) begin
				for (int k = 0; k < MAX_DEGREE; k++) begin
					if (32'(k) >= 32'(degree)) begin
						root_re_q[k] <= '0;
						root_im_q[k] <= '0;
					end
				end
			end
			if (evt.rebuild) begin
				pend_q <= 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result transfer into a full queue");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command taken from an empty queue");
	a_rebuild_first: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !pend_q)
		else $error("command started ahead of a pending rebuild");
	a_mul_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL && ph_q == 2'd3) |=> (state_q == S_FIN))
		else $error("product sequence did not end in combine step");
`endif

endmodule

### hdl/complex_poly_from_roots_eval.sv
// Complex polynomial from roots, with Horner evaluation.
// Input channel: a queue port (push / full). A transfer carries operation,
// slot and a complex value: write root, read coefficient or evaluate p(x).
// Result channel: a queue port (empty / pop); one result per input item,
// in order: answer_re, answer_im and status (ok, out of range, saturated).
// Configuration: APB write of degree, lead_re, lead_im at 0x0, 0x4, 0x8;
// each write queues a rebuild of the coefficients; no item starts while it is pending.
// One shared multiplier forms one real product per cycle; a complex
// multiply-accumulate forms its real products in turn, then combines them.
// Evaluation runs one multiply-accumulate per coefficient (Horner);
// a root write runs a full rebuild of the coefficients.
// Items are handled one at a time; a two-entry command queue and a
// two-entry result queue let the sender and the receiver stall on their own.
// When the receiver stalls, the result queue fills, the engine holds, then
// the command queue fills and full rises.
// Reset: degree 0, lead = one, all roots zero, coefficient 0 = one;
// both queues empty.
module complex_poly_from_roots_eval import cpr_pkg::*; #(
	parameter int MAX_DEGREE = DEF_MAX_DEGREE,
	parameter int PART_WIDTH = DEF_PART_WIDTH,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  operation,
	input  logic [4:0]  slot,
	input  logic [31:0] value_re,
	input  logic [31:0] value_im,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] answer_re,
	output logic [31:0] answer_im,
	output logic [1:0]  status,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int DW = $clog2(MAX_DEGREE + 1);
	localparam int PW = PART_WIDTH;
	localparam logic signed [PW-1:0] ONE = PW'(one_part(FRAC_BITS, PW));

	logic [DW-1:0]        degree_q;
	logic signed [PW-1:0] lead_re_q;
	logic signed [PW-1:0] lead_im_q;
	cfg_evt_t             evt_q;
	logic                 cfg_wr;
	logic [DW-1:0]        new_deg;

	cmd_t      cmd;
	logic      cmd_empty;
	logic      cmd_pop;
	out_item_t res;
	logic      res_push;
	logic      res_full;
	out_item_t out_item;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// clamp the degree to the table size
	assign new_deg = (32'(pwdata[4:0]) > 32'(MAX_DEGREE)) ? DW'(MAX_DEGREE) : DW'(pwdata[4:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q  <= '0;
			lead_re_q <= ONE;
			lead_im_q <= '0;
			evt_q     <= '0;
		end else begin
			// the engine sees the event in the cycle after the write, with the new value in place
			evt_q <= '0;
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_DEGREE: begin
						degree_q <= new_deg;
						evt_q    <= '{rebuild: 1'b1, clear_roots: 1'b1};
					end
					REG_LEAD_RE: begin
						lead_re_q <= signed'(pwdata[PW-1:0]);
						evt_q     <= '{rebuild: 1'b1, clear_roots: 1'b0};
					end
					REG_LEAD_IM: begin
						lead_im_q <= signed'(pwdata[PW-1:0]);
						evt_q     <= '{rebuild: 1'b1, clear_roots: 1'b0};
					end
					default: evt_q <= '0;
				endcase
			end
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_DEGREE:  prdata = 32'(degree_q);
			REG_LEAD_RE: prdata = 32'(lead_re_q);
			REG_LEAD_IM: prdata = 32'(lead_im_q);
			default:     prdata = '0;
		endcase
	end

	cpr_front #(.MAX_DEGREE(MAX_DEGREE)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.operation (operation),
		.slot      (slot),
		.value_re  (value_re),
		.value_im  (value_im),
		.degree    (degree_q),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.cmd_empty (cmd_empty)
	);

	cpr_engine #(
		.MAX_DEGREE (MAX_DEGREE),
		.PART_WIDTH (PART_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.degree    (degree_q),
		.lead_re   (lead_re_q),
		.lead_im   (lead_im_q),
		.evt       (evt_q),
		.cmd       (cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res       (res),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	cpr_fifo #(.item_t(out_item_t)) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (out_item),
		.empty   (empty)
	);

	assign answer_re = out_item.re;
	assign answer_im = out_item.im;
	assign status    = out_item.status;

endmodule

### bench/tb_complex_poly_from_roots_eval.sv
`timescale 1ns / 1ps

module tb_complex_poly_from_roots_eval;
	import cpr_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;
	// leave margin over the longest rebuild, at degree 16
	localparam int SETTLE_CYCLES = 1200;

	typedef struct {
		longint re;
		longint im;
	} cpx_t;

	typedef struct {
		logic [31:0] re;
		logic [31:0] im;
		logic [1:0]  st;
	} answer_t;

	typedef struct {
		logic [1:0]  op;
		logic [4:0]  slot;
		logic [31:0] re;
		logic [31:0] im;
		bit          typed;
		answer_t     want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  operation = '0;
	logic [4:0]  slot = '0;
	logic [31:0] value_re = '0;
	logic [31:0] value_im = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [31:0] answer_re;
	logic [31:0] answer_im;
	logic [1:0]  status;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// predictor state: a mirror of the block's registers and stores
	int      poly_degree;
	cpx_t    lead;
	cpx_t    roots[16];
	cpx_t    coefs[17];
	bit      clipped;

	answer_t pending_answers[$];
	int      error_count = 0;
	int      idle_cycles = 0;
	bit      quiet = 1'b0;

	complex_poly_from_roots_eval dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.operation(operation), .slot(slot), .value_re(value_re), .value_im(value_im),
		.empty(empty), .pop(pop),
		.answer_re(answer_re), .answer_im(answer_im), .status(status),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------
	// Fixed-point helpers: Q16.16 parts, floor on shift, saturate to 32 bits
	// ---------------------------------------------------------------
	function automatic longint clamp_part(logic signed [127:0] v);
		if (v > 128'sd2147483647) begin
			clipped = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -128'sd2147483648) begin
			clipped = 1'b1;
			return -64'sd2147483648;
		end
		return longint'(v);
	endfunction

	function automatic longint scaled_sum(longint p1, longint p2);
		logic signed [127:0] s;
		s = 128'(p1) + 128'(p2);
		return clamp_part(s >>> 16);
	endfunction

	function automatic cpx_t cmul(cpx_t a, cpx_t b);
		cpx_t r;
		r.re = scaled_sum(a.re * b.re, -(a.im * b.im));
		r.im = scaled_sum(a.re * b.im, a.im * b.re);
		return r;
	endfunction

	function automatic cpx_t cadd(cpx_t a, cpx_t b);
		cpx_t r;
		r.re = clamp_part(128'(a.re) + 128'(b.re));
		r.im = clamp_part(128'(a.im) + 128'(b.im));
		return r;
	endfunction

	function automatic cpx_t csub(cpx_t a, cpx_t b);
		cpx_t r;
		r.re = clamp_part(128'(a.re) - 128'(b.re));
		r.im = clamp_part(128'(a.im) - 128'(b.im));
		return r;
	endfunction

	// Expand lead * prod(x - r_i) into coefs by repeated multiplication.
	function automatic void rebuild_coefs();
		cpx_t work[17];
		cpx_t zero;
		zero = '{0, 0};
		foreach (coefs[i]) coefs[i] = zero;
		if (poly_degree == 0) begin
			coefs[0] = lead;
			return;
		end
		foreach (work[i]) work[i] = zero;
		work[0] = '{65536, 0};
		for (int i = 0; i < poly_degree; i++) begin
			work[i + 1] = work[i];
			for (int j = i; j >= 1; j--)
				work[j] = csub(work[j - 1], cmul(work[j], roots[i]));
			work[0] = csub(zero, cmul(work[0], roots[i]));
		end
		for (int i = 0; i <= poly_degree; i++) coefs[i] = cmul(work[i], lead);
	endfunction

	function automatic void reset_model();
		poly_degree = 0;
		lead = '{65536, 0};
		foreach (roots[i]) roots[i] = '{0, 0};
		foreach (coefs[i]) coefs[i] = '{0, 0};
		coefs[0] = lead;
	endfunction

	function automatic void apply_register(logic [1:0] idx, logic [31:0] data);
		int d;
		if (idx == REG_DEGREE) begin
			d = int'(data[4:0]);
			if (d > 16) d = 16;
			for (int i = d; i < 16; i++) roots[i] = '{0, 0};
			poly_degree = d;
		end else if (idx == REG_LEAD_RE) begin
			lead.re = longint'($signed(data));
		end else begin
			lead.im = longint'($signed(data));
		end
		rebuild_coefs();
	endfunction

	// Compute the answer of one accepted item and advance the mirror state.
	function automatic answer_t predict_answer(logic [1:0] op, logic [4:0] sl,
			logic [31:0] vre, logic [31:0] vim);
		answer_t a;
		cpx_t v, acc;
		v = '{longint'($signed(vre)), longint'($signed(vim))};
		acc = '{0, 0};
		a.st = ST_OK;
		clipped = 1'b0;
		if (op == OP_WRITE_ROOT) begin
			if (int'(sl) < poly_degree) begin
				roots[sl] = v;
				rebuild_coefs();
				if (clipped) a.st = ST_SAT;
			end else begin
				a.st = ST_RANGE;
			end
		end else if (op == OP_READ_COEF) begin
			if (int'(sl) <= poly_degree) acc = coefs[sl];
			else a.st = ST_RANGE;
		end else if (op == OP_EVALUATE) begin
			for (int i = poly_degree; i >= 0; i--) acc = cadd(cmul(acc, v), coefs[i]);
			if (clipped) a.st = ST_SAT;
		end else begin
			a.st = ST_RANGE;
		end
		a.re = acc.re[31:0];
		a.im = acc.im[31:0];
		return a;
	endfunction

	// ---------------------------------------------------------------
	// Random helpers
	// ---------------------------------------------------------------
	// Mostly small values so the polynomial stays in range; some extremes
	// and some raw 32-bit patterns so every bit toggles.
	function automatic logic [31:0] random_part();
		int sel;
		int mag;
		sel = $urandom_range(0, 9);
		if (sel == 0) return $urandom;
		if (sel == 1) return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
		mag = $urandom_range(8, 18);
		return 32'($urandom_range(0, (1 << mag) - 1) - (1 << (mag - 1)));
	endfunction

	function automatic int sender_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		error_count++;
		$display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
	endtask

	// ---------------------------------------------------------------
	// Input side: hold push until the transfer, queue the expectation
	// ---------------------------------------------------------------
	task automatic send_item(logic [1:0] op, logic [4:0] sl, logic [31:0] vre,
			logic [31:0] vim, bit typed = 1'b0, answer_t want = '{0, 0, 0});
		answer_t predicted;
		int gap;
		push      <= 1'b1;
		operation <= op;
		slot      <= sl;
		value_re  <= vre;
		value_im  <= vim;
		do @(posedge clk); while (full);
		predicted = predict_answer(op, sl, vre, vim);
		pending_answers.push_back(typed ? want : predicted);
		gap = sender_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop push, drain all results and let any rebuild finish before a write.
	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		apply_register(idx, data);
	endtask

	// A phase: fill every active root, then a random mix of all operations.
	task automatic run_phase(int count);
		int pick;
		int d;
		logic [4:0] sl;
		d = poly_degree;
		for (int i = 0; i < d; i++)
			send_item(OP_WRITE_ROOT, 5'(i), random_part(), random_part());
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 9) == 0) sl = 5'($urandom);
			else sl = 5'($urandom_range(0, d));
			// keep slow rebuilds rare at high degree
			if (pick < ((d > 8) ? 8 : 30))
				send_item(OP_WRITE_ROOT, sl, random_part(), random_part());
			else if (pick < 60)
				send_item(OP_READ_COEF, sl, $urandom, $urandom);
			else if (pick < 95)
				send_item(OP_EVALUATE, 5'($urandom), random_part(), random_part());
			else
				send_item(2'(CMD_REJECT), sl, $urandom, $urandom);
		end
	endtask

	// ---------------------------------------------------------------
	// Output side: random pop with bursts, long stalls and free runs
	// ---------------------------------------------------------------
	initial begin
		int rate;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 9) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(20, 200)) @(posedge clk);
			end else begin
				case ($urandom_range(0, 2))
					0: rate = 100;
					1: rate = 70;
					default: rate = 30;
				endcase
				repeat ($urandom_range(10, 100)) begin
					pop <= ($urandom_range(1, 100) <= rate);
					@(posedge clk);
				end
			end
		end
	end

	// Compare every result transfer against the oldest expectation.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && pop && !empty) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected result", answer_re, 32'h0);
			end else begin
				want = pending_answers.pop_front();
				if (answer_re !== want.re) report_mismatch("answer_re", answer_re, want.re);
				if (answer_im !== want.im) report_mismatch("answer_im", answer_im, want.im);
				if (status !== want.st) report_mismatch("status", 32'(status), 32'(want.st));
			end
		end
	end

	// Watchdog: count cycles without any transfer.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		stim_row_t rows[$];
		logic [31:0] lre, lim;
		int d;

		reset_model();
		// After reset: degree 0 and lead = one, so results read off directly.
		rows = '{
			'{OP_READ_COEF, 5'd0, 32'h0, 32'h0, 1'b1, '{32'h00010000, 32'h0, ST_OK}},
			'{OP_READ_COEF, 5'd1, 32'hffffffff, 32'hffffffff, 1'b1, '{32'h0, 32'h0, ST_RANGE}},
			'{OP_READ_COEF, 5'd31, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, ST_RANGE}},
			'{OP_WRITE_ROOT, 5'd0, 32'h7fffffff, 32'h80000000, 1'b1, '{32'h0, 32'h0, ST_RANGE}},
			'{OP_WRITE_ROOT, 5'd31, 32'h80000000, 32'h7fffffff, 1'b1, '{32'h0, 32'h0, ST_RANGE}},
			'{2'(CMD_REJECT), 5'd0, 32'hffffffff, 32'h0, 1'b1, '{32'h0, 32'h0, ST_RANGE}},
			'{2'(CMD_REJECT), 5'd31, 32'h0, 32'hffffffff, 1'b1, '{32'h0, 32'h0, ST_RANGE}},
			'{OP_EVALUATE, 5'd0, 32'h7fffffff, 32'h80000000, 1'b1, '{32'h00010000, 32'h0, ST_OK}},
			'{OP_EVALUATE, 5'd31, 32'h0, 32'h0, 1'b1, '{32'h00010000, 32'h0, ST_OK}},
			'{OP_READ_COEF, 5'd16, 32'h0, 32'h0, 1'b0, '{32'h0, 32'h0, ST_OK}}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_item(rows[i].op, rows[i].slot, rows[i].re, rows[i].im, rows[i].typed,
				rows[i].want);

		// Sweep settings: full degree, clamped degree, lead extremes, then random.
		for (int ph = 0; ph < 16; ph++) begin
			wait_idle();
			case (ph)
				0: begin d = 16; lre = 32'h00010000; lim = 32'h0; end
				1: begin d = 31; lre = 32'h7fffffff; lim = 32'h80000000; end
				2: begin d = 0; lre = 32'h80000000; lim = 32'h7fffffff; end
				3: begin d = 1; lre = 32'hffffffff; lim = 32'h00000000; end
				4: begin d = 2; lre = 32'h00000000; lim = 32'h00010000; end
				default: begin
					d = $urandom_range(0, 20);
					lre = random_part();
					lim = ($urandom_range(0, 2) == 0) ? random_part() : 32'h0;
				end
			endcase
			quiet = ($urandom_range(0, 3) == 0);
			// random high bits ride along in the degree write
			write_register(REG_DEGREE, {27'($urandom), 5'(d)});
			write_register(REG_LEAD_RE, lre);
			write_register(REG_LEAD_IM, lim);
			run_phase(ph < 2 ? 40 : 66);
		end
		push <= 1'b0;

		while (pending_answers.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
